### rtl/core/script_language_lexer_unit_assert.svh
// Assertion macros used by the lexer RTL.
`ifndef SCRIPT_LANGUAGE_LEXER_UNIT_ASSERT_SVH
`define SCRIPT_LANGUAGE_LEXER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SLX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another on the next edge.
`define SLX_ASSERT_NEXT(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) \
		else $error(msg);

`endif

### rtl/core/slx_pkg.sv
package slx_pkg;

	localparam int unsigned MAX_SOURCE_BYTES_DEF = 65536;
	localparam int unsigned KEYWORD_CHARS_DEF = 6;
	localparam int unsigned MAX_OUT = 3;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam logic [15:0] LINE_CAP = 16'hFFFF;

	typedef logic [5:0] kind_t;

	localparam kind_t K_LPAREN = 6'd0;
	localparam kind_t K_RPAREN = 6'd1;
	localparam kind_t K_LBRACE = 6'd2;
	localparam kind_t K_RBRACE = 6'd3;
	localparam kind_t K_COMMA = 6'd4;
	localparam kind_t K_DOT = 6'd5;
	localparam kind_t K_MINUS = 6'd6;
	localparam kind_t K_PLUS = 6'd7;
	localparam kind_t K_SEMI = 6'd8;
	localparam kind_t K_SLASH = 6'd9;
	localparam kind_t K_STAR = 6'd10;
	localparam kind_t K_BANG = 6'd11;
	localparam kind_t K_BANG_EQ = 6'd12;
	localparam kind_t K_EQUAL = 6'd13;
	localparam kind_t K_EQUAL_EQ = 6'd14;
	localparam kind_t K_GREATER = 6'd15;
	localparam kind_t K_GREATER_EQ = 6'd16;
	localparam kind_t K_LESS = 6'd17;
	localparam kind_t K_LESS_EQ = 6'd18;
	localparam kind_t K_IDENT = 6'd19;
	localparam kind_t K_STRING = 6'd20;
	localparam kind_t K_NUMBER = 6'd21;
	localparam kind_t K_KW_FIRST = 6'd22;
	localparam kind_t K_END = 6'd38;
	localparam kind_t K_UNTERM = 6'd39;
	localparam kind_t K_BADCHAR = 6'd40;

	typedef enum logic [11:0] {
		M_IDLE    = 12'b0000_0000_0001,
		M_IDENT   = 12'b0000_0000_0010,
		M_INT     = 12'b0000_0000_0100,
		M_INTDOT  = 12'b0000_0000_1000,
		M_FRAC    = 12'b0000_0001_0000,
		M_STRING  = 12'b0000_0010_0000,
		M_COMMENT = 12'b0000_0100_0000,
		M_SLASH   = 12'b0000_1000_0000,
		M_BANG    = 12'b0001_0000_0000,
		M_EQUAL   = 12'b0010_0000_0000,
		M_LESS    = 12'b0100_0000_0000,
		M_GREATER = 12'b1000_0000_0000
	} lex_mode_t;

	typedef struct packed {
		lex_mode_t   mode;
		logic [15:0] start;
		logic [15:0] off;
		logic [15:0] line;
	} lex_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [7:0]  bad;
	} token_t;

	// Keywords left-aligned, first character in the top byte.
	localparam logic [47:0] KW_TEXT [16] = '{
		{"and", 24'd0}, {"class", 8'd0}, {"else", 16'd0}, {"false", 8'd0},
		{"for", 24'd0}, {"fun", 24'd0}, {"if", 32'd0}, {"nil", 24'd0},
		{"or", 32'd0}, {"print", 8'd0}, {"return"}, {"super", 8'd0},
		{"this", 16'd0}, {"true", 16'd0}, {"var", 24'd0}, {"while", 8'd0}
	};
	localparam logic [3:0] KW_LEN [16] = '{
		4'd3, 4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3,
		4'd2, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5
	};

	function automatic kind_t kw_kind(input logic [47:0] pre, input logic [3:0] wlen);
		kind_t k;
		logic [47:0] mask;
		k = K_IDENT;
		for (int i = 0; i < 16; i++) begin
			for (int j = 0; j < 6; j++)
				mask[47 - 8 * j -: 8] = (j < int'(KW_LEN[i])) ? 8'hFF : 8'h00;
			if (wlen == KW_LEN[i] && (pre & mask) == KW_TEXT[i])
				k = K_KW_FIRST + 6'(i);
		end
		return k;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return (c inside {[8'h30:8'h39]});
	endfunction

	// Distance from one offset to another, zero if negative, saturating.
	function automatic logic [15:0] sat_span(input logic [16:0] from_o, input logic [16:0] to_o);
		logic [16:0] diff;
		diff = to_o - from_o;
		if (to_o < from_o)
			return 16'd0;
		return diff[16] ? 16'hFFFF : diff[15:0];
	endfunction

	function automatic token_t mk_tok(input kind_t k, input logic [15:0] s,
			input logic [15:0] l, input logic [15:0] ln, input logic [7:0] b);
		token_t t;
		t.kind = k;
		t.start = s;
		t.len = l;
		t.line = ln;
		t.bad = b;
		return t;
	endfunction

endpackage

### rtl/core/slx_step.sv
module slx_step #(
	parameter int unsigned KEYWORD_CHARS = 6,
	parameter int unsigned OFFSET_CAP = 65535,
	localparam int unsigned WLW = $clog2(KEYWORD_CHARS + 2),
	localparam int unsigned IW = $clog2(KEYWORD_CHARS)
) (
	input  slx_pkg::lex_state_t st,
	input  logic [WLW-1:0]      wlen_q,
	input  logic [7:0]          pre [KEYWORD_CHARS],
	input  logic [7:0]          c,
	output slx_pkg::lex_state_t nx,
	output logic [WLW-1:0]      wlen_d,
	output logic                pw_en,
	output logic [IW-1:0]       pw_idx,
	output slx_pkg::token_t     tok [slx_pkg::MAX_OUT],
	output logic [1:0]          n_tok
);
	import slx_pkg::*;

	localparam logic [15:0] CAP = 16'(OFFSET_CAP);

	logic        redo;
	logic        ended;
	logic [16:0] p17;
	logic [16:0] p1;
	logic [16:0] s17;
	logic [15:0] d;
	logic [47:0] pre_w;
	kind_t       k;
	logic        have_k;

	always_comb begin
		for (int j = 0; j < 6; j++)
			pre_w[47 - 8 * j -: 8] = pre[j];
	end

	always_comb begin
		redo = 1'b1;
		ended = 1'b0;
		n_tok = 2'd0;
		for (int i = 0; i < int'(MAX_OUT); i++)
			tok[i] = '0;
		nx = st;
		wlen_d = wlen_q;
		pw_en = 1'b0;
		pw_idx = '0;
		k = K_IDENT;
		have_k = 1'b0;
		p17 = {1'b0, st.off};
		p1 = p17 + 17'd1;
		s17 = {1'b0, st.start};
		d = (st.off != 16'd0) ? st.off - 16'd1 : 16'd0;

		// Close or extend the pending token.
		case (st.mode)
			M_IDENT: begin
				if (is_letter(c) || is_num(c)) begin
					if (wlen_q < WLW'(KEYWORD_CHARS)) begin
						pw_en = 1'b1;
						pw_idx = wlen_q[IW-1:0];
						wlen_d = wlen_q + WLW'(1);
					end else begin
						wlen_d = WLW'(KEYWORD_CHARS + 1);
					end
					redo = 1'b0;
				end else begin
					tok[n_tok] = mk_tok(kw_kind(pre_w, 4'(wlen_q)), st.start,
						sat_span(s17, p17), st.line, 8'd0);
					n_tok = n_tok + 2'd1;
				end
			end
			M_INT: begin
				if (is_num(c)) begin
					redo = 1'b0;
				end else if (c == 8'h2E) begin
					nx.mode = M_INTDOT;
					redo = 1'b0;
				end else begin
					tok[n_tok] = mk_tok(K_NUMBER, st.start, sat_span(s17, p17), st.line, 8'd0);
					n_tok = n_tok + 2'd1;
				end
			end
			M_INTDOT: begin
				if (is_num(c)) begin
					nx.mode = M_FRAC;
					redo = 1'b0;
				end else begin
					tok[0] = mk_tok(K_NUMBER, st.start, sat_span(s17, {1'b0, d}),
						st.line, 8'd0);
					tok[1] = mk_tok(K_DOT, d, 16'd1, st.line, 8'd0);
					n_tok = 2'd2;
				end
			end
			M_FRAC: begin
				if (is_num(c)) begin
					redo = 1'b0;
				end else begin
					tok[n_tok] = mk_tok(K_NUMBER, st.start, sat_span(s17, p17), st.line, 8'd0);
					n_tok = n_tok + 2'd1;
				end
			end
			M_STRING: begin
				if (c == 8'h22) begin
					tok[n_tok] = mk_tok(K_STRING, st.start, sat_span(s17, p1), st.line, 8'd0);
					n_tok = n_tok + 2'd1;
					nx.mode = M_IDLE;
					redo = 1'b0;
				end else if (c == 8'h00) begin
					tok[n_tok] = mk_tok(K_UNTERM, st.start, sat_span(s17, p17), st.line, 8'd0);
					n_tok = n_tok + 2'd1;
				end else begin
					if (c == 8'h0A && st.line < LINE_CAP)
						nx.line = st.line + 16'd1;
					redo = 1'b0;
				end
			end
			M_COMMENT: begin
				if (c != 8'h0A && c != 8'h00)
					redo = 1'b0;
			end
			M_SLASH: begin
				if (c == 8'h2F) begin
					nx.mode = M_COMMENT;
					redo = 1'b0;
				end else begin
					tok[n_tok] = mk_tok(K_SLASH, st.start, sat_span(s17, p17), st.line, 8'd0);
					n_tok = n_tok + 2'd1;
				end
			end
			M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
				k = (st.mode == M_BANG) ? K_BANG : (st.mode == M_EQUAL) ? K_EQUAL :
					(st.mode == M_LESS) ? K_LESS : K_GREATER;
				if (c == 8'h3D) begin
					tok[n_tok] = mk_tok(k + 6'd1, st.start, sat_span(s17, p1), st.line, 8'd0);
					n_tok = n_tok + 2'd1;
					nx.mode = M_IDLE;
					redo = 1'b0;
				end else begin
					tok[n_tok] = mk_tok(k, st.start, sat_span(s17, p17), st.line, 8'd0);
					n_tok = n_tok + 2'd1;
				end
			end
			default: ;
		endcase

		// Start a new token from this byte.
		if (redo) begin
			nx.mode = M_IDLE;
			nx.start = st.off;
			case (c) inside
				8'h00: begin
					tok[n_tok] = mk_tok(K_END, st.off, 16'd0, st.line, 8'd0);
					n_tok = n_tok + 2'd1;
					nx.start = 16'd0;
					nx.off = 16'd0;
					nx.line = 16'd1;
					wlen_d = '0;
					ended = 1'b1;
				end
				8'h20, 8'h0D, 8'h09: ;
				8'h0A: if (st.line < LINE_CAP) nx.line = st.line + 16'd1;
				8'h2F: nx.mode = M_SLASH;
				8'h21: nx.mode = M_BANG;
				8'h3D: nx.mode = M_EQUAL;
				8'h3C: nx.mode = M_LESS;
				8'h3E: nx.mode = M_GREATER;
				8'h22: nx.mode = M_STRING;
				8'h28: begin k = K_LPAREN; have_k = 1'b1; end
				8'h29: begin k = K_RPAREN; have_k = 1'b1; end
				8'h7B: begin k = K_LBRACE; have_k = 1'b1; end
				8'h7D: begin k = K_RBRACE; have_k = 1'b1; end
				8'h2C: begin k = K_COMMA; have_k = 1'b1; end
				8'h2E: begin k = K_DOT; have_k = 1'b1; end
				8'h2D: begin k = K_MINUS; have_k = 1'b1; end
				8'h2B: begin k = K_PLUS; have_k = 1'b1; end
				8'h3B: begin k = K_SEMI; have_k = 1'b1; end
				8'h2A: begin k = K_STAR; have_k = 1'b1; end
				default: begin
					if (is_letter(c)) begin
						nx.mode = M_IDENT;
						pw_en = 1'b1;
						pw_idx = '0;
						wlen_d = WLW'(1);
					end else if (is_num(c)) begin
						nx.mode = M_INT;
					end else begin
						tok[n_tok] = mk_tok(K_BADCHAR, st.off, 16'd1, st.line, c);
						n_tok = n_tok + 2'd1;
					end
				end
			endcase
			if (have_k) begin
				tok[n_tok] = mk_tok(k, st.off, 16'd1, st.line, 8'd0);
				n_tok = n_tok + 2'd1;
			end
		end

		if (!ended)
			nx.off = (st.off < CAP) ? st.off + 16'd1 : CAP;
	end

endmodule

### rtl/core/slx_fifo.sv
module slx_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_n,
	input  slx_pkg::token_t push_tok [slx_pkg::MAX_OUT],
	output logic            room,
	output logic            pop_valid,
	input  logic            pop_ready,
	output slx_pkg::token_t pop_tok,
	output logic            pop_last,
	output logic [2:0]      count
);
	import slx_pkg::*;

	token_t     ent_q [FIFO_DEPTH];
	logic       last_q [FIFO_DEPTH];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop = pop_valid && pop_ready;
	assign pop_valid = (cnt_q != 3'd0);
	assign pop_tok = ent_q[rptr_q];
	assign pop_last = last_q[rptr_q];
	assign room = (cnt_q <= 3'(FIFO_DEPTH - MAX_OUT));
	assign count = cnt_q;

	// Store payload without reset.
	always_ff @(posedge clk) begin
		for (int i = 0; i < int'(MAX_OUT); i++) begin
			if (i < int'(push_n)) begin
				ent_q[wptr_q + 2'(i)] <= push_tok[i];
				last_q[wptr_q + 2'(i)] <= (i == int'(push_n) - 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wptr_q <= wptr_q + push_n;
			if (pop)
				rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b0, pop};
		end
	end

endmodule

### rtl/core/script_language_lexer_unit.sv
// Streaming source lexer. Feed one source byte per word on the input channel;
// a zero byte ends the text, emits the end token and returns the lexer to its
// reset state. Each token comes out as one word carrying kind, start offset,
// length, line and the offending byte for bad-character errors; last_of_run
// marks the final token caused by a given input byte. A byte is accepted in
// any cycle while the four-entry token queue has room for three tokens, so
// the block takes one byte per cycle as long as the output side drains; a
// byte that closes a number before a dot and opens a one-character token
// yields three tokens; one token leaves per cycle while out_ready is high.
module script_language_lexer_unit #(
	parameter int unsigned MAX_SOURCE_BYTES = slx_pkg::MAX_SOURCE_BYTES_DEF,
	parameter int unsigned KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [15:0] start_offset,
	output logic [15:0] lexeme_length,
	output logic [15:0] line_number,
	output logic [7:0]  bad_char,
	output logic        last_of_run
);
	import slx_pkg::*;

	`include "script_language_lexer_unit_assert.svh"

	localparam int unsigned OFFSET_CAP =
		(MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : MAX_SOURCE_BYTES - 1;
	localparam int unsigned WLW = $clog2(KEYWORD_CHARS + 2);
	localparam int unsigned IW = $clog2(KEYWORD_CHARS);

	lex_state_t     st_q;
	lex_state_t     st_d;
	logic [WLW-1:0] wlen_q;
	logic [WLW-1:0] wlen_d;
	logic [7:0]     pre_q [KEYWORD_CHARS];
	logic           pw_en;
	logic [IW-1:0]  pw_idx;
	token_t         tok [MAX_OUT];
	logic [1:0]     n_tok;
	logic           acc;
	logic           room;
	logic [2:0]     q_count;
	token_t         head;

	assign acc = in_valid && in_ready;
	assign in_ready = room;

	slx_step #(
		.KEYWORD_CHARS(KEYWORD_CHARS),
		.OFFSET_CAP(OFFSET_CAP)
	) u_step (
		.st(st_q),
		.wlen_q(wlen_q),
		.pre(pre_q),
		.c(char_byte),
		.nx(st_d),
		.wlen_d(wlen_d),
		.pw_en(pw_en),
		.pw_idx(pw_idx),
		.tok(tok),
		.n_tok(n_tok)
	);

	// Push only the tokens of an accepted byte.
	slx_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(acc ? n_tok : 2'd0),
		.push_tok(tok),
		.room(room),
		.pop_valid(out_valid),
		.pop_ready(out_ready),
		.pop_tok(head),
		.pop_last(last_of_run),
		.count(q_count)
	);

	assign token_kind = head.kind;
	assign start_offset = head.start;
	assign lexeme_length = head.len;
	assign line_number = head.line;
	assign bad_char = head.bad;

	// Identifier prefix buffer: entries are read only after being written.
	always_ff @(posedge clk) begin
		if (acc && pw_en)
			pre_q[pw_idx] <= char_byte;
	end

	// Advance lexer state on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode <= M_IDLE;
			st_q.start <= 16'd0;
			st_q.off <= 16'd0;
			st_q.line <= 16'd1;
			wlen_q <= '0;
		end else if (acc) begin
			st_q <= st_d;
			wlen_q <= wlen_d;
		end
	end

	`SLX_ASSERT(a_queue_bound, q_count <= 3'(FIFO_DEPTH), "token queue overflow")
	`SLX_ASSERT_NEXT(a_end_clears, acc && char_byte == 8'h00,
		st_q.off == 16'd0 && st_q.line == 16'd1 && st_q.mode == M_IDLE,
		"end byte did not restore reset state")
	`SLX_ASSERT_NEXT(a_line_monotonic, acc && char_byte != 8'h00,
		st_q.line >= $past(st_q.line), "line counter went backward")
	`SLX_ASSERT(a_line_nonzero, st_q.line != 16'd0, "line counter reached zero")

endmodule

### test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import slx_pkg::*;

	// One expected token as the lexer should deliver it.
	typedef struct {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [7:0]  bad;
		logic        last;
	} token_word_t;

	localparam int OFFSET_LIMIT = 65535;
	localparam int LINE_LIMIT = 65535;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_byte;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  token_kind;
	logic [15:0] start_offset;
	logic [15:0] lexeme_length;
	logic [15:0] line_number;
	logic [7:0]  bad_char;
	logic        last_of_run;

	script_language_lexer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .char_byte(char_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .start_offset(start_offset),
		.lexeme_length(lexeme_length), .line_number(line_number),
		.bad_char(bad_char), .last_of_run(last_of_run)
	);

	// Tokens predicted but not yet seen on the output, oldest first.
	token_word_t tokens_due[$];
	token_word_t fresh[$];
	int errors = 0;
	int bytes_sent = 0;
	int tokens_seen = 0;
	bit quiet = 0;
	bit hold_req = 0;

	// Shadow lexer state.
	lex_mode_t   mode;
	int          tok_start;
	int          next_off;
	int          line_cnt;
	logic [7:0]  prefix [6];
	int          prefix_len;

	string kw_words [16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
		"or", "print", "return", "super", "this", "true", "var", "while"};

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic bit letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic int gap_len(input int from_o, input int to_o);
		return to_o >= from_o ? to_o - from_o : 0;
	endfunction

	function automatic void clear_lexer();
		mode = M_IDLE;
		tok_start = 0;
		next_off = 0;
		line_cnt = 1;
		prefix_len = 0;
	endfunction

	function automatic void emit(input logic [5:0] k, input int s, input int l,
			input logic [7:0] b);
		token_word_t t;
		if (fresh.size() >= MAX_OUT)
			return;
		t.kind = k;
		t.start = s[15:0];
		t.len = l > 65535 ? 16'hFFFF : l[15:0];
		t.line = line_cnt[15:0];
		t.bad = b;
		t.last = 0;
		fresh.push_back(t);
	endfunction

	// Match the held prefix against the keyword list.
	function automatic logic [5:0] word_kind();
		bit hit;
		for (int i = 0; i < 16; i++) begin
			hit = kw_words[i].len() == prefix_len;
			for (int j = 0; j < prefix_len && hit; j++)
				if (prefix[j] != kw_words[i][j])
					hit = 0;
			if (hit)
				return K_KW_FIRST + 6'(i);
		end
		return K_IDENT;
	endfunction

	// Start a new lexeme at offset p; return 1 when the text ends here.
	function automatic bit lex_from_idle(input logic [7:0] c, input int p);
		logic [5:0] k;
		bit single;
		single = 1;
		tok_start = p;
		case (c)
		8'h00: begin
			emit(K_END, p, 0, 0);
			clear_lexer();
			return 1;
		end
		" ", "\r", "\t": return 0;
		"\n": begin
			if (line_cnt < LINE_LIMIT)
				line_cnt++;
			return 0;
		end
		"/": begin mode = M_SLASH; return 0; end
		"!": begin mode = M_BANG; return 0; end
		"=": begin mode = M_EQUAL; return 0; end
		"<": begin mode = M_LESS; return 0; end
		">": begin mode = M_GREATER; return 0; end
		"\"": begin mode = M_STRING; return 0; end
		"(": k = K_LPAREN;
		")": k = K_RPAREN;
		"{": k = K_LBRACE;
		"}": k = K_RBRACE;
		",": k = K_COMMA;
		".": k = K_DOT;
		"-": k = K_MINUS;
		"+": k = K_PLUS;
		";": k = K_SEMI;
		"*": k = K_STAR;
		default: single = 0;
		endcase
		if (single)
			emit(k, p, 1, 0);
		else if (letter(c)) begin
			mode = M_IDENT;
			prefix[0] = c;
			prefix_len = 1;
		end else if (digit(c))
			mode = M_INT;
		else
			emit(K_BADCHAR, p, 1, c);
		return 0;
	endfunction

	// Advance the shadow lexer by one byte and queue the tokens it yields.
	function automatic void predict_tokens(input logic [7:0] c);
		int p;
		int d;
		bit restart;
		bit ended;
		logic [5:0] base;
		p = next_off;
		restart = 1;
		ended = 0;
		fresh.delete();
		case (mode)
		M_IDENT:
			if (letter(c) || digit(c)) begin
				if (prefix_len < 6) begin
					prefix[prefix_len] = c;
					prefix_len++;
				end else
					prefix_len = 7;
				restart = 0;
			end else
				emit(word_kind(), tok_start, gap_len(tok_start, p), 0);
		M_INT:
			if (digit(c))
				restart = 0;
			else if (c == ".") begin
				mode = M_INTDOT;
				restart = 0;
			end else
				emit(K_NUMBER, tok_start, gap_len(tok_start, p), 0);
		M_INTDOT:
			if (digit(c)) begin
				mode = M_FRAC;
				restart = 0;
			end else begin
				d = p > 0 ? p - 1 : 0;
				emit(K_NUMBER, tok_start, gap_len(tok_start, d), 0);
				emit(K_DOT, d, 1, 0);
			end
		M_FRAC:
			if (digit(c))
				restart = 0;
			else
				emit(K_NUMBER, tok_start, gap_len(tok_start, p), 0);
		M_STRING:
			if (c == "\"") begin
				emit(K_STRING, tok_start, gap_len(tok_start, p + 1), 0);
				mode = M_IDLE;
				restart = 0;
			end else if (c == 0)
				emit(K_UNTERM, tok_start, gap_len(tok_start, p), 0);
			else begin
				if (c == "\n" && line_cnt < LINE_LIMIT)
					line_cnt++;
				restart = 0;
			end
		M_COMMENT:
			if (c != "\n" && c != 0)
				restart = 0;
		M_SLASH:
			if (c == "/") begin
				mode = M_COMMENT;
				restart = 0;
			end else
				emit(K_SLASH, tok_start, gap_len(tok_start, p), 0);
		M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
			base = mode == M_BANG ? K_BANG : mode == M_EQUAL ? K_EQUAL :
				mode == M_LESS ? K_LESS : K_GREATER;
			if (c == "=") begin
				emit(base + 6'd1, tok_start, gap_len(tok_start, p + 1), 0);
				mode = M_IDLE;
				restart = 0;
			end else
				emit(base, tok_start, gap_len(tok_start, p), 0);
		end
		default: ;
		endcase
		if (restart) begin
			mode = M_IDLE;
			ended = lex_from_idle(c, p);
		end
		if (!ended)
			next_off = p < OFFSET_LIMIT ? p + 1 : OFFSET_LIMIT;
		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1;
		foreach (fresh[i])
			tokens_due.push_back(fresh[i]);
	endfunction

	// Offer one byte, wait for the handshake, predict its tokens.
	// Valid stays high afterwards; only an idle gap drops it.
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1;
		char_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_tokens(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Compare each delivered token with the oldest prediction.
	always @(posedge clk) begin
		token_word_t e;
		if (arst_n && out_valid && out_ready) begin
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected token kind %0d at %0d", $time, token_kind,
					start_offset);
			end else begin
				e = tokens_due.pop_front();
				if (token_kind !== e.kind || start_offset !== e.start ||
						lexeme_length !== e.len || line_number !== e.line ||
						bad_char !== e.bad || last_of_run !== e.last) begin
					errors++;
					$display({"%0t: token mismatch expected kind %0d start %0d len %0d",
						" line %0d bad %0h last %0b"},
						$time, e.kind, e.start, e.len, e.line, e.bad, e.last);
					$display({"%0t:                actual kind %0d start %0d len %0d",
						" line %0d bad %0h last %0b"},
						$time, token_kind, start_offset, lexeme_length, line_number,
						bad_char, last_of_run);
				end
			end
		end
	end

	// Output side: random ready bursts, a long hold on request, steady in quiet phase.
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				hold_req = 0;
				out_ready <= 1;
			end else if (quiet) begin
				out_ready <= 1;
			end else if ($urandom_range(0, 3) != 0) begin
				out_ready <= 1;
				repeat ($urandom_range(0, 15)) @(posedge clk);
			end else begin
				out_ready <= 0;
				repeat ($urandom_range(0, 15)) @(posedge clk);
			end
		end
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	// Single-character tokens, blanks and the end of text.
	task automatic test_punctuation();
		send_text("(){},.-+;* \t\r*");
		send_byte(0);
	endtask

	// Operators !=, <= and >=, the one-character = and <, and lone slashes.
	task automatic test_operators();
		send_text("!=!==<=<>=>=/a/");
		send_byte(0);
	endtask

	task automatic test_keywords();
		foreach (kw_words[i])
			send_text({kw_words[i], " "});
		send_text("returns classy _Az09 x");
		send_byte(0);
	endtask

	// Numbers with and without fraction, a number followed by a bare dot.
	task automatic test_numbers();
		send_text("0 12.5 9.;7.x 3");
		send_byte(0);
	endtask

	task automatic test_strings_comments();
		send_text("\"a\nb\" // note ( \n+\"open\n");
		send_byte(0);
	endtask

	task automatic test_bad_bytes();
		send_byte("@");
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(0);
	endtask

	// Hold the output off while bytes keep coming so the token queue fills.
	task automatic test_backpressure();
		hold_req = 1;
		repeat (15) send_text("9.;");
		send_byte(0);
		wait (!hold_req);
	endtask

	task automatic make_fragment(ref logic [7:0] frag[$]);
		string s;
		string punct;
		int n;
		punct = "(){},.-+;*/";
		n = $urandom_range(0, 19);
		s = "";
		case (n)
		0, 1: s = kw_words[$urandom_range(0, 15)];
		2, 3: begin
			repeat ($urandom_range(1, 9)) begin
				case ($urandom_range(0, 3))
				0: s = {s, string'(8'($urandom_range("a", "z")))};
				1: s = {s, string'(8'($urandom_range("A", "Z")))};
				2: s = {s, "_"};
				default: s = {s, string'(8'($urandom_range("0", "9")))};
				endcase
			end
			if (!letter(s[0]))
				s = {"q", s};
		end
		4, 5: begin
			repeat ($urandom_range(1, 4)) s = {s, string'(8'($urandom_range("0", "9")))};
			case ($urandom_range(0, 2))
			0: s = {s, "."};
			1: begin
				s = {s, "."};
				repeat ($urandom_range(1, 3))
					s = {s, string'(8'($urandom_range("0", "9")))};
			end
			default: ;
			endcase
		end
		6: begin
			if ($urandom_range(0, 1))
				s = "\"x y\nz\"";
			else
				s = "\"\"";
		end
		7: s = "// skip this\n";
		8, 9: begin
			case ($urandom_range(0, 3))
			0: s = "!";
			1: s = "=";
			2: s = "<";
			default: s = ">";
			endcase
			if ($urandom_range(0, 1))
				s = {s, "="};
		end
		10, 11: s = string'(punct[$urandom_range(0, 10)]);
		12, 13, 14: begin
			case ($urandom_range(0, 3))
			0: s = " ";
			1: s = "\n";
			2: s = "\t";
			default: s = "\r";
			endcase
		end
		15: s = "\"unfinished";
		default: begin
			// Noise: any byte except the end marker.
			frag.push_back(8'($urandom_range(1, 255)));
			return;
		end
		endcase
		for (int i = 0; i < s.len(); i++)
			frag.push_back(s[i]);
		if ($urandom_range(0, 1))
			frag.push_back(" ");
	endtask

	// Mostly well-formed source with random content, an end byte now and then.
	task automatic test_random(input int count);
		logic [7:0] frag[$];
		int sent;
		sent = 0;
		while (sent < count) begin
			frag.delete();
			make_fragment(frag);
			foreach (frag[i])
				send_byte(frag[i]);
			sent += frag.size();
			if ($urandom_range(0, 9) == 0) begin
				send_byte(0);
				sent++;
			end
			if (sent >= count * 3 / 4)
				quiet = 1;
		end
		send_byte(0);
	endtask

	initial begin
		int waited;
		arst_n = 0;
		in_valid = 0;
		char_byte = 0;
		clear_lexer();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_punctuation();
		test_operators();
		test_keywords();
		test_numbers();
		test_strings_comments();
		test_bad_bytes();
		test_backpressure();
		test_random(184);

		@(posedge clk);
		in_valid <= 0;
		waited = 0;
		while (tokens_due.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);

		$display("Fed %0d source bytes: punctuation, operators, keywords, numbers,", bytes_sent);
		$display("strings, comments, bad bytes, random text and a long output stall; %0d tokens checked.",
			tokens_seen);
		if (errors == 0 && tokens_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/slx_pkg.sv
rtl/core/slx_step.sv
rtl/core/slx_fifo.sv
rtl/core/script_language_lexer_unit.sv
test/tb.sv
